[design/mpa_pkg.sv]
package mpa_pkg;

    // one g in Q4.12
    localparam logic [15:0] ONE_G = 16'd4096;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    // event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_START   = 3'd1;
    localparam logic [2:0] EV_STOP    = 3'd2;
    localparam logic [2:0] EV_NEAR    = 3'd3;
    localparam logic [2:0] EV_FAR     = 3'd4;
    localparam logic [2:0] EV_TIMEOUT = 3'd5;

    // mode codes
    localparam logic [1:0] MODE_IDLE      = 2'd0;
    localparam logic [1:0] MODE_DETECTING = 2'd1;
    localparam logic [1:0] MODE_TRACKING  = 2'd2;
    localparam logic [1:0] MODE_ALERT     = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_MOTION_DELTA   = 3'd0;
    localparam logic [2:0] CFG_MOTION_LEVEL   = 3'd1;
    localparam logic [2:0] CFG_REST_TOLERANCE = 3'd2;
    localparam logic [2:0] CFG_NEAR_LIMIT     = 3'd3;
    localparam logic [2:0] CFG_FAR_LIMIT      = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT_TICKS  = 3'd5;
    localparam logic [2:0] CFG_NEXT_STATE_TBL = 3'd6;

    localparam int CFG_DATA_W = 48;
    localparam int TBL_ENTRIES = 24;

    // register reset values
    localparam logic [15:0] RST_MOTION_DELTA   = 16'd1229;
    localparam logic [15:0] RST_MOTION_LEVEL   = 16'd4915;
    localparam logic [15:0] RST_REST_TOLERANCE = 16'd410;
    localparam logic [14:0] RST_NEAR_LIMIT     = 15'd800;
    localparam logic [14:0] RST_FAR_LIMIT      = 15'd1600;
    localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd10000;
    localparam logic [47:0] RST_NEXT_STATE_TBL = 48'd192370680811524;

    typedef struct packed {
        logic               action;
        logic signed [15:0] distance;
        logic [15:0]        magnitude;
    } t_in_word;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] event_res;
        logic       changed;
    } t_out_word;

    typedef struct packed {
        logic [15:0]                     motion_delta;
        logic [15:0]                     motion_level;
        logic [15:0]                     rest_tolerance;
        logic [14:0]                     near_limit;
        logic [14:0]                     far_limit;
        logic [15:0]                     timeout_ticks;
        logic [TBL_ENTRIES-1:0][1:0]     next_state_table;
    } t_cfg;

    // next state of the machine for one word
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] elapsed;
        logic [15:0] last_magnitude;
        logic [2:0]  event_res;
        logic        changed;
    } t_eval;

endpackage

[design/mpa_cfg_regs.sv]
module mpa_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [47:0]           i_cfg_data,
    output mpa_pkg::t_cfg         o_cfg
);
    import mpa_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register write decode; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MOTION_DELTA:   n_cfg.motion_delta   = i_cfg_data[15:0];
                CFG_MOTION_LEVEL:   n_cfg.motion_level   = i_cfg_data[15:0];
                CFG_REST_TOLERANCE: n_cfg.rest_tolerance = i_cfg_data[15:0];
                CFG_NEAR_LIMIT:     n_cfg.near_limit     = i_cfg_data[14:0];
                CFG_FAR_LIMIT:      n_cfg.far_limit      = i_cfg_data[14:0];
                CFG_TIMEOUT_TICKS:  n_cfg.timeout_ticks  = i_cfg_data[15:0];
                CFG_NEXT_STATE_TBL: n_cfg.next_state_table = i_cfg_data[CFG_DATA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motion_delta     <= RST_MOTION_DELTA;
            r_cfg.motion_level     <= RST_MOTION_LEVEL;
            r_cfg.rest_tolerance   <= RST_REST_TOLERANCE;
            r_cfg.near_limit       <= RST_NEAR_LIMIT;
            r_cfg.far_limit        <= RST_FAR_LIMIT;
            r_cfg.timeout_ticks    <= RST_TIMEOUT_TICKS;
            r_cfg.next_state_table <= RST_NEXT_STATE_TBL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/mpa_eval.sv]
module mpa_eval (
    input  mpa_pkg::t_cfg     i_cfg,
    input  mpa_pkg::t_in_word i_word,
    input  logic [1:0]        i_mode,
    input  logic [15:0]       i_elapsed,
    input  logic [15:0]       i_last_mag,
    output mpa_pkg::t_eval    o_eval
);
    import mpa_pkg::*;

    logic [15:0] mag_diff;
    logic [15:0] rest_diff;
    logic        dist_pos;
    logic        ev_start;
    logic        ev_stop;
    logic        ev_near;
    logic        ev_far;
    logic        ev_timeout;
    logic [2:0]  ev;
    logic [4:0]  entry;
    logic [1:0]  tbl_mode;
    logic        mode_chg;

    // magnitude distances
    assign mag_diff  = (i_word.magnitude > i_last_mag) ? (i_word.magnitude - i_last_mag)
                                                       : (i_last_mag - i_word.magnitude);
    assign rest_diff = (i_word.magnitude > ONE_G) ? (i_word.magnitude - ONE_G)
                                                  : (ONE_G - i_word.magnitude);

    // event conditions; a negative distance is never near or far
    assign dist_pos   = !i_word.distance[15];
    assign ev_start   = (mag_diff > i_cfg.motion_delta) && (i_word.magnitude > i_cfg.motion_level);
    assign ev_stop    = (rest_diff < i_cfg.rest_tolerance) && (i_last_mag > i_cfg.motion_level);
    assign ev_near    = dist_pos && (i_word.distance[14:0] != 15'd0)
                        && (i_word.distance[14:0] < i_cfg.near_limit);
    assign ev_far     = dist_pos && (i_word.distance[14:0] > i_cfg.far_limit);
    assign ev_timeout = i_elapsed > i_cfg.timeout_ticks;

    // fixed priority
    always_comb begin
        if (ev_start)        ev = EV_START;
        else if (ev_stop)    ev = EV_STOP;
        else if (ev_near)    ev = EV_NEAR;
        else if (ev_far)     ev = EV_FAR;
        else if (ev_timeout) ev = EV_TIMEOUT;
        else                 ev = EV_NONE;
    end

    // table entry mode*6+event
    assign entry    = {1'b0, i_mode, 2'b00} + {2'b00, i_mode, 1'b0} + {2'b00, ev};
    assign tbl_mode = i_cfg.next_state_table[entry];
    assign mode_chg = (ev != EV_NONE) && (tbl_mode != i_mode);

    // next state for a tick or a sample
    always_comb begin
        o_eval.mode           = i_mode;
        o_eval.elapsed        = i_elapsed;
        o_eval.last_magnitude = i_last_mag;
        o_eval.event_res      = ev;
        o_eval.changed        = 1'b0;
        if (!i_word.action) begin
            if (i_elapsed != ELAPSED_MAX) begin
                o_eval.elapsed = i_elapsed + 16'd1;
            end
        end else begin
            o_eval.last_magnitude = i_word.magnitude;
            if (mode_chg) begin
                o_eval.mode    = tbl_mode;
                o_eval.elapsed = 16'd0;
                o_eval.changed = 1'b1;
            end
        end
    end

endmodule

[design/motion_proximity_alert_fsm.sv]
// Motion and proximity alert state machine. Each input word is either a tick
// (action 0), which advances the saturating elapsed-in-mode counter and gives
// no output word, or a sensor sample (action 1), which is classified into one
// event and may move the mode through the 4x6 next-state table; each sample
// gives exactly one output word with the mode after it, the event and a
// changed flag. A word is taken every cycle unless a sample waits on a stalled
// output: it is registered at the input, evaluated combinationally against the
// mode, elapsed and last-magnitude registers, and its result lands in the output
// register together with the state update, so the sustained rate is one word per
// cycle while the output does not stall. Registers may be rewritten only while idle.
module motion_proximity_alert_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mpa_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mpa_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data
);
    import mpa_pkg::*;

    t_cfg      cfg;
    t_eval     eval;
    t_in_word  r_in;
    logic      r_in_valid;
    t_out_word r_out;
    logic      r_out_valid;
    logic [1:0]  r_mode;
    logic [15:0] r_elapsed;
    logic [15:0] r_last_mag;
    logic      out_free;
    logic      adv;
    logic      in_acc;

    mpa_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mpa_eval u_eval (
        .i_cfg      (cfg),
        .i_word     (r_in),
        .i_mode     (r_mode),
        .i_elapsed  (r_elapsed),
        .i_last_mag (r_last_mag),
        .o_eval     (eval)
    );

    // flow control: ticks never wait on the output side
    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && (!r_in.action || out_free);
    assign o_in_stall = r_in_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_word;
        end
    end

    // machine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_elapsed  <= 16'd0;
            r_last_mag <= ONE_G;
        end else if (adv) begin
            r_mode     <= eval.mode;
            r_elapsed  <= eval.elapsed;
            r_last_mag <= eval.last_magnitude;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in.action) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in.action) begin
            r_out.mode      <= eval.mode;
            r_out.event_res <= eval.event_res;
            r_out.changed   <= eval.changed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // a tick below saturation bumps elapsed by one
    a_tick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_in.action && r_elapsed != ELAPSED_MAX)
            |=> r_elapsed == $past(r_elapsed) + 16'd1)
        else $error("elapsed did not advance on tick");

    // mode moves only on a sample
    a_mode_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(adv && r_in.action) |=> $stable(r_mode))
        else $error("mode changed without a sample");

    // the reported mode is the mode the machine now holds
    a_out_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.action) |=> (r_out_valid && r_out.mode == r_mode))
        else $error("output mode disagrees with state");

    // a change always comes with an event and clears elapsed
    a_chg_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.action && eval.changed)
            |=> (r_out.event_res != EV_NONE && r_elapsed == 16'd0))
        else $error("mode change without event or elapsed clear");

    // a waiting word is not dropped
    a_out_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled output word lost");

endmodule
